>>> hdl/pfsc_pkg.sv
`default_nettype none
package pfsc_pkg;

    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int TABLE_LEN           = 24;

    localparam int POS_W  = 24;
    localparam int DIFF_W = 25;
    localparam int Q_W    = 16;
    localparam int RATE_W = 16;
    localparam int GAIN_W = 16;
    localparam int LIM_W  = 15;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;
    localparam int VEC_W  = 35;
    localparam int ROT_W  = 33;
    localparam int CS_W   = ROT_W - 16;

    localparam logic [IDX_W-1:0] REG_ALONG_GAIN   = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEADING_GAIN = 2'd1;
    localparam logic [IDX_W-1:0] REG_LATERAL_GAIN = 2'd2;
    localparam logic [IDX_W-1:0] REG_MAX_TURN     = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;
    localparam logic [LIM_W-1:0]  LIM_RESET  = 15'd4096;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30    = 64'sd652032874;

    localparam longint ATAN_Q30 [TABLE_LEN] = '{
        64'sh3243F6A8, 64'sh1DAC6705, 64'sh0FADBAFC, 64'sh07F56EA6,
        64'sh03FEAB76, 64'sh01FFD55B, 64'sh00FFFAAA, 64'sh007FFF55,
        64'sh003FFFEA, 64'sh001FFFFD, 64'sh000FFFFF, 64'sh0007FFFF,
        64'sh0003FFFF, 64'sh0001FFFF, 64'sh0000FFFF, 64'sh00007FFF,
        64'sh00003FFF, 64'sh00001FFF, 64'sh00000FFF, 64'sh000007FF,
        64'sh000003FF, 64'sh000001FF, 64'sh000000FF, 64'sh0000007F
    };

    // q30 angle rounded half up to the angle format
    function automatic longint to_angle(input longint q30, input int frac);
        return (q30 + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
    endfunction

    function automatic longint atan_angle(input int idx, input int frac);
        return to_angle(ATAN_Q30[idx], frac);
    endfunction

    function automatic longint sat_s(input longint v, input int w);
        longint hi;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        if (v > hi)
            return hi;
        else if (v < -hi - 64'sd1)
            return -hi - 64'sd1;
        return v;
    endfunction

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [RATE_W-1:0] gv;
        logic signed [RATE_W-1:0] gw;
        logic                     mzero;
        logic                     gzero;
    } vside_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [RATE_W-1:0] gv;
        logic signed [RATE_W-1:0] gw;
    } rside_t;

    typedef struct packed {
        logic [GAIN_W-1:0] along_gain;
        logic [GAIN_W-1:0] heading_gain;
        logic [GAIN_W-1:0] lateral_gain;
        logic [LIM_W-1:0]  max_turn_rate;
    } cfg_t;

endpackage
`default_nettype wire

>>> hdl/path_following_steering_control.sv
// path following steering controller
// start/busy command channel: a beat is taken at every clock edge with start
// high; busy is tied low, so a new beat may follow in every cycle.
// each beat carries measured and desired pose plus speed and turn feedforward.
// one result beat per input, on the result ports for one cycle with done high.
// throughput one beat per cycle: two vectoring cordic chains find both
// headings, one rotation chain gives cos/sin of the desired heading, then a
// five stage projection and gain pipeline.
// the receiver cannot stall; results are presented once and not held.
// config: cfg_we writes cfg_data to register cfg_index in the same edge;
// write only while no beat is in flight.
// reset clears the pipeline valid bits and loads the default gains
// (1.0 each) and a turn rate limit of 1.0 rad/s.
`default_nettype none
module path_following_steering_control
    import pfsc_pkg::*;
#(
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire logic signed [POS_W-1:0] meas_x,
    input  wire logic signed [POS_W-1:0] meas_y,
    input  wire logic signed [Q_W-1:0]   meas_qz,
    input  wire logic signed [Q_W-1:0]   meas_qw,
    input  wire logic signed [POS_W-1:0] goal_x,
    input  wire logic signed [POS_W-1:0] goal_y,
    input  wire logic signed [Q_W-1:0]   goal_qz,
    input  wire logic signed [Q_W-1:0]   goal_qw,
    input  wire logic signed [RATE_W-1:0] goal_speed,
    input  wire logic signed [RATE_W-1:0] goal_turn_rate,
    input  wire                          cfg_we,
    input  wire logic [IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    output logic                         done,
    output logic signed [RATE_W-1:0]     speed_cmd,
    output logic signed [RATE_W-1:0]     turn_rate_cmd,
    output logic signed [POS_W-1:0]      lateral_error,
    output logic signed [POS_W-1:0]      along_error,
    output logic signed [15:0]           heading_error,
    output logic                         turn_limited
);

    localparam int N   = CORDIC_STAGES;
    localparam int AW  = ANGLE_FRAC_BITS + 6;
    localparam int LAT = 2 * N + 7;

    localparam logic signed [AW-1:0] PI_A  = AW'(to_angle(PI_Q30, ANGLE_FRAC_BITS));
    localparam logic signed [AW-1:0] HP_A  = AW'(to_angle(HALF_PI_Q30, ANGLE_FRAC_BITS));
    localparam logic signed [ROT_W-1:0] K0 = ROT_W'(GAIN_Q30);

    // configuration
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.along_gain    <= GAIN_RESET;
            cfg_reg.heading_gain  <= GAIN_RESET;
            cfg_reg.lateral_gain  <= GAIN_RESET;
            cfg_reg.max_turn_rate <= LIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ALONG_GAIN:   cfg_reg.along_gain    <= cfg_data;
                REG_HEADING_GAIN: cfg_reg.heading_gain  <= cfg_data;
                REG_LATERAL_GAIN: cfg_reg.lateral_gain  <= cfg_data;
                REG_MAX_TURN:     cfg_reg.max_turn_rate <= cfg_data[LIM_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign busy = 1'b0;

    // quaternion to vectoring start point, left half plane folded by +-pi/2
    function automatic void prerot(input logic signed [Q_W-1:0] qz,
                                   input logic signed [Q_W-1:0] qw,
                                   output logic signed [VEC_W-1:0] xo,
                                   output logic signed [VEC_W-1:0] yo,
                                   output logic signed [AW-1:0] zo);
        logic signed [VEC_W-1:0] xw, yw;
        xw = VEC_W'($signed({qw, 16'h0000}));
        yw = VEC_W'($signed({qz, 16'h0000}));
        if (qw < 0)
        begin
            if (qz >= 0)
            begin
                xo = yw;
                yo = -xw;
                zo = HP_A;
            end
            else
            begin
                xo = -yw;
                yo = xw;
                zo = -HP_A;
            end
        end
        else
        begin
            xo = xw;
            yo = yw;
            zo = '0;
        end
    endfunction

    function automatic logic signed [AW-1:0] wrap(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] t;
        t = a;
        if (t > PI_A)
            t = t - (PI_A <<< 1);
        if (t > PI_A)
            t = t - (PI_A <<< 1);
        if (t < -PI_A)
            t = t + (PI_A <<< 1);
        if (t < -PI_A)
            t = t + (PI_A <<< 1);
        return t;
    endfunction

    // input stage
    logic signed [VEC_W-1:0] mx_next, my_next, gx_next, gy_next;
    logic signed [AW-1:0]    mz_next, gz_next;
    vside_t                  vs_next;

    always_comb
    begin
        prerot(meas_qz, meas_qw, mx_next, my_next, mz_next);
        prerot(goal_qz, goal_qw, gx_next, gy_next, gz_next);
        vs_next.dx    = DIFF_W'(goal_x) - DIFF_W'(meas_x);
        vs_next.dy    = DIFF_W'(goal_y) - DIFF_W'(meas_y);
        vs_next.gv    = goal_speed;
        vs_next.gw    = goal_turn_rate;
        vs_next.mzero = (meas_qz == '0) && (meas_qw == '0);
        vs_next.gzero = (goal_qz == '0) && (goal_qw == '0);
    end

    logic signed [VEC_W-1:0] mvx [N+1];
    logic signed [VEC_W-1:0] mvy [N+1];
    logic signed [AW-1:0]    mvz [N+1];
    logic signed [VEC_W-1:0] gvx [N+1];
    logic signed [VEC_W-1:0] gvy [N+1];
    logic signed [AW-1:0]    gvz [N+1];
    logic signed [VEC_W-1:0] mx_reg, my_reg, gx_reg, gy_reg;
    logic signed [AW-1:0]    mz_reg, gz_reg;
    vside_t                  vsb_reg [N+1];
    logic [N:0]              vv_reg;

    always_ff @(posedge clk)
    begin
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        mz_reg     <= mz_next;
        gx_reg     <= gx_next;
        gy_reg     <= gy_next;
        gz_reg     <= gz_next;
        vsb_reg[0] <= vs_next;
        for (int k = 0; k < N; k++)
            vsb_reg[k+1] <= vsb_reg[k];
    end

    assign mvx[0] = mx_reg;
    assign mvy[0] = my_reg;
    assign mvz[0] = mz_reg;
    assign gvx[0] = gx_reg;
    assign gvy[0] = gy_reg;
    assign gvz[0] = gz_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_vec
        pfsc_vec_cell #(.IDX(k), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .AW(AW)) u_meas
        (
            .clk   (clk),
            .x_in  (mvx[k]),
            .y_in  (mvy[k]),
            .z_in  (mvz[k]),
            .x_out (mvx[k+1]),
            .y_out (mvy[k+1]),
            .z_out (mvz[k+1])
        );
        pfsc_vec_cell #(.IDX(k), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .AW(AW)) u_goal
        (
            .clk   (clk),
            .x_in  (gvx[k]),
            .y_in  (gvy[k]),
            .z_in  (gvz[k]),
            .x_out (gvx[k+1]),
            .y_out (gvy[k+1]),
            .z_out (gvz[k+1])
        );
    end

    // heading stage: double, wrap, heading error
    logic signed [AW-1:0] psi_m, psi_g, psi_gw_next, herr_next;
    logic signed [AW-1:0] pg_reg, hw_reg;
    rside_t               rs_next, rsw_reg;
    logic                 vw_reg;

    always_comb
    begin
        psi_m       = vsb_reg[N].mzero ? '0 : (mvz[N] <<< 1);
        psi_g       = vsb_reg[N].gzero ? '0 : (gvz[N] <<< 1);
        psi_gw_next = wrap(psi_g);
        herr_next   = wrap(psi_g - psi_m);
        rs_next.dx  = vsb_reg[N].dx;
        rs_next.dy  = vsb_reg[N].dy;
        rs_next.gv  = vsb_reg[N].gv;
        rs_next.gw  = vsb_reg[N].gw;
    end

    always_ff @(posedge clk)
    begin
        pg_reg  <= psi_gw_next;
        hw_reg  <= herr_next;
        rsw_reg <= rs_next;
    end

    // rotation chain start point
    logic signed [ROT_W-1:0] rx [N+1];
    logic signed [ROT_W-1:0] ry [N+1];
    logic signed [AW-1:0]    ra [N+1];
    logic signed [ROT_W-1:0] rx_start, ry_start;
    logic signed [AW-1:0]    ra_start;

    always_comb
    begin
        priority if (pg_reg > HP_A)
        begin
            rx_start = '0;
            ry_start = K0;
            ra_start = pg_reg - HP_A;
        end
        else if (pg_reg < -HP_A)
        begin
            rx_start = '0;
            ry_start = -K0;
            ra_start = pg_reg + HP_A;
        end
        else
        begin
            rx_start = K0;
            ry_start = '0;
            ra_start = pg_reg;
        end
    end

    assign rx[0] = rx_start;
    assign ry[0] = ry_start;
    assign ra[0] = ra_start;

    for (genvar k = 0; k < N; k++)
    begin : g_rot
        pfsc_rot_cell #(.IDX(k), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .AW(AW)) u_rot
        (
            .clk   (clk),
            .x_in  (rx[k]),
            .y_in  (ry[k]),
            .a_in  (ra[k]),
            .x_out (rx[k+1]),
            .y_out (ry[k+1]),
            .a_out (ra[k+1])
        );
    end

    rside_t               rsb_reg [N];
    logic signed [AW-1:0] hsb_reg [N];
    logic [N-1:0]         rv_reg;

    always_ff @(posedge clk)
    begin
        rsb_reg[0] <= rsw_reg;
        hsb_reg[0] <= hw_reg;
        for (int k = 1; k < N; k++)
        begin
            rsb_reg[k] <= rsb_reg[k-1];
            hsb_reg[k] <= hsb_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vv_reg <= '0;
            vw_reg <= 1'b0;
            rv_reg <= '0;
        end
        else
        begin
            vv_reg <= {vv_reg[N-1:0], start};
            vw_reg <= vv_reg[N];
            rv_reg <= {rv_reg[N-2:0], vw_reg};
        end
    end

    pfsc_ctrl_law #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .AW(AW)) u_law
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (rv_reg[N-1]),
        .cos_raw       (rx[N]),
        .sin_raw       (ry[N]),
        .side          (rsb_reg[N-1]),
        .herr          (hsb_reg[N-1]),
        .cfg           (cfg_reg),
        .done          (done),
        .speed_cmd     (speed_cmd),
        .turn_rate_cmd (turn_rate_cmd),
        .lateral_error (lateral_error),
        .along_error   (along_error),
        .heading_error (heading_error),
        .turn_limited  (turn_limited)
    );

    // a result only ever follows an accepted beat by the fixed pipeline depth
    a_done_after_start : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without matching input beat");

    a_limited_at_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (done && turn_limited) |->
            ((turn_rate_cmd == $signed({1'b0, cfg_reg.max_turn_rate}))
          || (turn_rate_cmd == -$signed({1'b0, cfg_reg.max_turn_rate}))))
        else $error("clamped turn rate not at the limit");

    a_unlimited_inside : assert property (@(posedge clk) disable iff (!rst_n)
        (done && !turn_limited) |->
            ((turn_rate_cmd <= $signed({1'b0, cfg_reg.max_turn_rate}))
          && (turn_rate_cmd >= -$signed({1'b0, cfg_reg.max_turn_rate}))))
        else $error("unclamped turn rate outside the limit");

endmodule
`default_nettype wire

>>> hdl/pfsc_vec_cell.sv
`default_nettype none
module pfsc_vec_cell
    import pfsc_pkg::*;
#(
    parameter int IDX             = 0,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int AW              = ANGLE_FRAC_BITS_DEF + 6
)
(
    input  wire                        clk,
    input  wire logic signed [VEC_W-1:0] x_in,
    input  wire logic signed [VEC_W-1:0] y_in,
    input  wire logic signed [AW-1:0]    z_in,
    output logic signed [VEC_W-1:0]      x_out,
    output logic signed [VEC_W-1:0]      y_out,
    output logic signed [AW-1:0]         z_out
);

    localparam logic signed [AW-1:0] ATAN = AW'(atan_angle(IDX, ANGLE_FRAC_BITS));

    logic signed [VEC_W-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [AW-1:0]    z_reg, z_next;
    logic signed [VEC_W-1:0] xs, ys;

    always_comb
    begin
        xs = x_in >>> IDX;
        ys = y_in >>> IDX;
        // drive y toward zero
        if (y_in >= 0)
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule
`default_nettype wire

>>> hdl/pfsc_rot_cell.sv
`default_nettype none
module pfsc_rot_cell
    import pfsc_pkg::*;
#(
    parameter int IDX             = 0,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int AW              = ANGLE_FRAC_BITS_DEF + 6
)
(
    input  wire                        clk,
    input  wire logic signed [ROT_W-1:0] x_in,
    input  wire logic signed [ROT_W-1:0] y_in,
    input  wire logic signed [AW-1:0]    a_in,
    output logic signed [ROT_W-1:0]      x_out,
    output logic signed [ROT_W-1:0]      y_out,
    output logic signed [AW-1:0]         a_out
);

    localparam logic signed [AW-1:0] ATAN = AW'(atan_angle(IDX, ANGLE_FRAC_BITS));

    logic signed [ROT_W-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [AW-1:0]    a_reg, a_next;
    logic signed [ROT_W-1:0] xs, ys;

    always_comb
    begin
        xs = x_in >>> IDX;
        ys = y_in >>> IDX;
        // drive residual angle toward zero
        if (a_in >= 0)
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            a_next = a_in - ATAN;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            a_next = a_in + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        a_reg <= a_next;
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign a_out = a_reg;

endmodule
`default_nettype wire

>>> hdl/pfsc_ctrl_law.sv
`default_nettype none
module pfsc_ctrl_law
    import pfsc_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int AW              = ANGLE_FRAC_BITS_DEF + 6
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    input  wire logic signed [ROT_W-1:0] cos_raw,
    input  wire logic signed [ROT_W-1:0] sin_raw,
    input  wire rside_t                  side,
    input  wire logic signed [AW-1:0]    herr,
    input  wire cfg_t                    cfg,
    output logic                         done,
    output logic signed [RATE_W-1:0]     speed_cmd,
    output logic signed [RATE_W-1:0]     turn_rate_cmd,
    output logic signed [POS_W-1:0]      lateral_error,
    output logic signed [POS_W-1:0]      along_error,
    output logic signed [15:0]           heading_error,
    output logic                         turn_limited
);

    localparam int PW = DIFF_W + CS_W;
    localparam int HW = GAIN_W + 1 + AW;
    localparam int EW = GAIN_W + 1 + POS_W;

    logic [4:0] v_reg;

    // p0: rounded cos/sin
    logic signed [CS_W-1:0]   c_reg, s_reg;
    logic signed [ROT_W-1:0]  c_full, s_full;
    rside_t                   sd0_reg, sd1_reg, sd2_reg, sd3_reg;
    logic signed [AW-1:0]     h0_reg, h1_reg, h2_reg, h3_reg;

    // p1: projection products
    logic signed [PW-1:0] dxc_reg, dys_reg, dyc_reg, dxs_reg;

    // p2: errors
    logic signed [POS_W-1:0] lat_reg, alg_reg, lat_next, alg_next;

    // p3: gain products
    logic signed [EW-1:0] ga_reg, gl_reg;
    logic signed [HW-1:0] gh_reg;
    logic signed [POS_W-1:0] lat3_reg, alg3_reg;

    // p4: outputs
    logic signed [RATE_W-1:0] speed_reg, speed_next, turn_reg, turn_next;
    logic signed [POS_W-1:0]  lat4_reg, alg4_reg;
    logic signed [15:0]       herr_reg, herr_next;
    logic                     lim_reg, lim_next;

    longint lat_sum, alg_sum, turn_sum, lim_l, sp;

    assign c_full = cos_raw + ROT_W'(32768);
    assign s_full = sin_raw + ROT_W'(32768);

    always_comb
    begin
        lat_sum  = (longint'(dyc_reg) - longint'(dxs_reg) + 64'sd8192) >>> 14;
        alg_sum  = (longint'(dxc_reg) + longint'(dys_reg) + 64'sd8192) >>> 14;
        lat_next = POS_W'(sat_s(lat_sum, POS_W));
        alg_next = POS_W'(sat_s(alg_sum, POS_W));

        sp = longint'(sd3_reg.gv) + ((longint'(ga_reg) + 64'sd2048) >>> 12);
        speed_next = RATE_W'(sat_s(sp, RATE_W));
        turn_sum = longint'(sd3_reg.gw)
                 + ((longint'(gh_reg) + (64'sd1 <<< (ANGLE_FRAC_BITS - 5)))
                    >>> (ANGLE_FRAC_BITS - 4))
                 + ((longint'(gl_reg) + 64'sd2048) >>> 12);
        lim_l = longint'({1'b0, cfg.max_turn_rate});
        priority if (turn_sum > lim_l)
        begin
            turn_next = RATE_W'(lim_l);
            lim_next  = 1'b1;
        end
        else if (turn_sum < -lim_l)
        begin
            turn_next = RATE_W'(-lim_l);
            lim_next  = 1'b1;
        end
        else
        begin
            turn_next = RATE_W'(turn_sum);
            lim_next  = 1'b0;
        end
        herr_next = 16'(sat_s(longint'(h3_reg), 16));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        c_reg   <= c_full[ROT_W-1:16];
        s_reg   <= s_full[ROT_W-1:16];
        sd0_reg <= side;
        h0_reg  <= herr;

        dxc_reg <= PW'(sd0_reg.dx * c_reg);
        dys_reg <= PW'(sd0_reg.dy * s_reg);
        dyc_reg <= PW'(sd0_reg.dy * c_reg);
        dxs_reg <= PW'(sd0_reg.dx * s_reg);
        sd1_reg <= sd0_reg;
        h1_reg  <= h0_reg;

        lat_reg <= lat_next;
        alg_reg <= alg_next;
        sd2_reg <= sd1_reg;
        h2_reg  <= h1_reg;

        ga_reg   <= EW'($signed({1'b0, cfg.along_gain}) * alg_reg);
        gl_reg   <= EW'($signed({1'b0, cfg.lateral_gain}) * lat_reg);
        gh_reg   <= HW'($signed({1'b0, cfg.heading_gain}) * h2_reg);
        lat3_reg <= lat_reg;
        alg3_reg <= alg_reg;
        sd3_reg  <= sd2_reg;
        h3_reg   <= h2_reg;

        speed_reg <= speed_next;
        turn_reg  <= turn_next;
        lim_reg   <= lim_next;
        herr_reg  <= herr_next;
        lat4_reg  <= lat3_reg;
        alg4_reg  <= alg3_reg;
    end

    assign done          = v_reg[4];
    assign speed_cmd     = speed_reg;
    assign turn_rate_cmd = turn_reg;
    assign lateral_error = lat4_reg;
    assign along_error   = alg4_reg;
    assign heading_error = herr_reg;
    assign turn_limited  = lim_reg;

endmodule
`default_nettype wire
